@@ sv/assert_macros.svh @@
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that holds on every enabled clock edge
`define TNSI_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// cause on one edge, effect on the next edge
`define TNSI_ASSERT_NEXT(lbl, clk, rst_n, cause, effect, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) \
        else $error(msg);

`endif

@@ sv/tnsi_pkg.sv @@
// types, codes and constants of the top-n score table
// no dependencies
`default_nettype none

package tnsi_pkg;

    localparam int TABLE_DEPTH_DEF = 8;
    localparam int SCORE_W         = 32;
    localparam int SLOT_W          = 3;
    localparam int RANK_W          = 3;
    localparam int CMD_W           = 2;
    localparam int SCORE_BASE      = 500;
    localparam int SCORE_STEP      = 100;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_READ   = 2'd1,
        CMD_LOAD   = 2'd2
    } t_cmd;

    typedef enum logic {
        ST_IDLE,
        ST_SORT
    } t_state;

    typedef struct packed {
        logic [CMD_W-1:0]          command;
        logic signed [SCORE_W-1:0] score;
        logic [SLOT_W-1:0]         slot;
    } t_in;

    typedef struct packed {
        logic                      accepted;
        logic [RANK_W-1:0]         rank;
        logic signed [SCORE_W-1:0] slot_value;
    } t_out;

    typedef struct packed {
        logic                      wr_en;
        logic signed [SCORE_W-1:0] wr_val;
        logic                      sort_en;
        logic                      phase;
    } t_cell_ctl;

endpackage

`default_nettype wire

@@ sv/tnsi_cell.sv @@
// one table cell: holds one score, compare-exchange with a neighbor
// depends on tnsi_pkg
`default_nettype none

module tnsi_cell #(
    parameter int TABLE_DEPTH = tnsi_pkg::TABLE_DEPTH_DEF,
    parameter int IDX         = 0
) (
    input  wire                                       i_clk,
    input  wire                                       i_rst_n,
    input  wire tnsi_pkg::t_cell_ctl                  i_ctl,
    input  wire logic signed [tnsi_pkg::SCORE_W-1:0]  i_left,
    input  wire logic signed [tnsi_pkg::SCORE_W-1:0]  i_right,
    output logic signed [tnsi_pkg::SCORE_W-1:0]       o_value
);

    localparam logic signed [tnsi_pkg::SCORE_W-1:0] RESET_VAL =
        tnsi_pkg::SCORE_W'(tnsi_pkg::SCORE_BASE
                           + tnsi_pkg::SCORE_STEP * (TABLE_DEPTH - 1 - IDX));
    localparam logic PAR       = 1'(IDX % 2);
    localparam bit   HAS_RIGHT = (IDX < TABLE_DEPTH - 1);
    localparam bit   HAS_LEFT  = (IDX > 0);

    logic signed [tnsi_pkg::SCORE_W-1:0] r_value;
    logic signed [tnsi_pkg::SCORE_W-1:0] n_value;

    always_comb begin
        n_value = r_value;
        if (i_ctl.wr_en) begin
            n_value = i_ctl.wr_val;
        end else if (i_ctl.sort_en) begin
            if (i_ctl.phase == PAR) begin
                // upper member of the pair keeps the larger value
                if (HAS_RIGHT && (i_right > r_value)) begin
                    n_value = i_right;
                end
            end else begin
                if (HAS_LEFT && (i_left < r_value)) begin
                    n_value = i_left;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value <= RESET_VAL;
        end else begin
            r_value <= n_value;
        end
    end

    assign o_value = r_value;

endmodule

`default_nettype wire

@@ sv/top_n_score_insert.sv @@
// top level of the top-n score table: command decode, sort sequencer, cell row
// depends on tnsi_pkg and tnsi_cell
`default_nettype none

// Keeps the TABLE_DEPTH best scores in descending order, slot 0 best.
// Input: a command (insert, read, load) with score and slot is taken at a
// rising edge where start is high and busy is low.
// Output: every command gives exactly one result, shown on o_out for one
// cycle while o_done is high; the receiver cannot hold it off.
// Read, load, unused codes and an insert that does not beat the last slot
// need no sorting: the result shows in the cycle after the transfer,
// busy stays low and a new command may follow in that very cycle.
// An insert that beats the last slot writes it into the last cell, then the
// cell row runs TABLE_DEPTH odd-even compare-exchange steps, one per cycle,
// while the rank counter adds one greater-than flag per step. busy is high
// while the steps run, and the result is registered at the end of the last step.
// Reset (synchronous, active low) loads each slot i with
// 500 + 100 * (TABLE_DEPTH - 1 - i) and returns the sequencer to idle.

module top_n_score_insert #(
    parameter int TABLE_DEPTH = tnsi_pkg::TABLE_DEPTH_DEF
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   start,
    input  wire tnsi_pkg::t_in    i_in,
    output logic                  busy,
    output logic                  o_done,
    output tnsi_pkg::t_out        o_out
);

    localparam int STEP_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [STEP_W-1:0]          LAST_STEP = STEP_W'(TABLE_DEPTH - 1);
    localparam logic [tnsi_pkg::RANK_W-1:0] RANK_MAX = '1;

    tnsi_pkg::t_state r_state;
    tnsi_pkg::t_state n_state;
    logic [STEP_W-1:0]           r_step;
    logic [STEP_W-1:0]           n_step;
    logic [tnsi_pkg::RANK_W-1:0] r_rank;
    logic [tnsi_pkg::RANK_W-1:0] n_rank;
    logic [tnsi_pkg::RANK_W-1:0] rank_next;
    logic [TABLE_DEPTH-1:0]      r_gt;
    logic [TABLE_DEPTH-1:0]      n_gt;
    logic                        r_done;
    logic                        n_done;
    tnsi_pkg::t_out              r_out;
    tnsi_pkg::t_out              n_out;

    logic [TABLE_DEPTH-1:0]                  wr_vec;
    logic signed [tnsi_pkg::SCORE_W-1:0]     w_value [TABLE_DEPTH];
    tnsi_pkg::t_cell_ctl                     w_ctl   [TABLE_DEPTH];

    // cell row
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        logic signed [tnsi_pkg::SCORE_W-1:0] w_left;
        logic signed [tnsi_pkg::SCORE_W-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = w_value[g];
        end else begin : g_mid_l
            assign w_left = w_value[g-1];
        end
        if (g == TABLE_DEPTH - 1) begin : g_last
            assign w_right = w_value[g];
        end else begin : g_mid_r
            assign w_right = w_value[g+1];
        end

        assign w_ctl[g].wr_en   = wr_vec[g];
        assign w_ctl[g].wr_val  = i_in.score;
        assign w_ctl[g].sort_en = (r_state == tnsi_pkg::ST_SORT);
        assign w_ctl[g].phase   = r_step[0];

        tnsi_cell #(
            .TABLE_DEPTH (TABLE_DEPTH),
            .IDX         (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl[g]),
            .i_left  (w_left),
            .i_right (w_right),
            .o_value (w_value[g])
        );
    end

    // saturating rank count
    assign rank_next = (r_rank == RANK_MAX) ? r_rank
                     : r_rank + tnsi_pkg::RANK_W'(r_gt[r_step]);

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_rank  = r_rank;
        n_gt    = r_gt;
        n_done  = 1'b0;
        n_out   = r_out;
        wr_vec  = '0;
        case (r_state)
            tnsi_pkg::ST_IDLE: begin
                if (start) begin
                    n_done = 1'b1;
                    n_out  = '0;
                    case (tnsi_pkg::t_cmd'(i_in.command))
                        tnsi_pkg::CMD_INSERT: begin
                            if (i_in.score > w_value[TABLE_DEPTH-1]) begin
                                n_done                = 1'b0;
                                wr_vec[TABLE_DEPTH-1] = 1'b1;
                                for (int i = 0; i < TABLE_DEPTH - 1; i++) begin
                                    n_gt[i] = (w_value[i] > i_in.score);
                                end
                                n_gt[TABLE_DEPTH-1] = 1'b0;
                                n_step  = '0;
                                n_rank  = '0;
                                n_state = tnsi_pkg::ST_SORT;
                            end
                        end
                        tnsi_pkg::CMD_READ: begin
                            for (int i = 0; i < TABLE_DEPTH; i++) begin
                                if (int'(i_in.slot) == i) begin
                                    n_out.slot_value = w_value[i];
                                end
                            end
                        end
                        tnsi_pkg::CMD_LOAD: begin
                            for (int i = 0; i < TABLE_DEPTH; i++) begin
                                if (int'(i_in.slot) == i) begin
                                    wr_vec[i] = 1'b1;
                                end
                            end
                        end
                        default: begin
                            n_out = '0;
                        end
                    endcase
                end
            end
            tnsi_pkg::ST_SORT: begin
                n_rank = rank_next;
                n_step = r_step + 1'b1;
                if (r_step == LAST_STEP) begin
                    n_state        = tnsi_pkg::ST_IDLE;
                    n_done         = 1'b1;
                    n_out          = '0;
                    n_out.accepted = 1'b1;
                    n_out.rank     = rank_next;
                end
            end
            default: begin
                n_state = tnsi_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tnsi_pkg::ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_step <= n_step;
        r_rank <= n_rank;
        r_gt   <= n_gt;
        r_out  <= n_out;
    end

    assign busy   = (r_state == tnsi_pkg::ST_SORT);
    assign o_done = r_done;
    assign o_out  = r_out;

endmodule

`default_nettype wire

@@ sv/tnsi_checker.sv @@
// port-level checker of the top-n score table, bound to the top level
// depends on tnsi_pkg and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module tnsi_checker (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 start,
    input wire tnsi_pkg::t_in  i_in,
    input wire                 busy,
    input wire                 o_done,
    input wire tnsi_pkg::t_out o_out
);

    // busy only follows a transfer
    `TNSI_ASSERT(a_busy_after_xfer, i_clk, i_rst_n, $rose(busy) |-> $past(start && !busy), "busy rose without transfer")

    // a read gives its result in the next cycle with no insert fields
    `TNSI_ASSERT_NEXT(a_read_result, i_clk, i_rst_n, start && !busy && (i_in.command == tnsi_pkg::CMD_READ), o_done && !o_out.accepted && (o_out.rank == '0), "read result wrong")

    // a load gives its result in the next cycle with all fields zero
    `TNSI_ASSERT_NEXT(a_load_result, i_clk, i_rst_n, start && !busy && (i_in.command == tnsi_pkg::CMD_LOAD), o_done && (o_out == '0), "load result wrong")

    // a rejected insert carries no rank
    `TNSI_ASSERT(a_reject_rank, i_clk, i_rst_n, (o_done && !o_out.accepted) |-> (o_out.rank == '0), "rank without accept")

endmodule

bind top_n_score_insert tnsi_checker u_tnsi_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .i_in    (i_in),
    .busy    (busy),
    .o_done  (o_done),
    .o_out   (o_out)
);

`default_nettype wire

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps

// testbench for top_n_score_insert: a directed table of commands, then random
// commands, reloads and inserts with random gaps, checked against a local score table
// depends on tnsi_pkg and top_n_score_insert

module tb;
    import tnsi_pkg::*;

    localparam int DEPTH        = TABLE_DEPTH_DEF;
    localparam int N_RANDOM     = 950;
    localparam int IDLE_LIMIT   = 500;
    localparam int DRAIN_CYCLES = DEPTH + 4;
    localparam int RANK_MAX     = (1 << RANK_W) - 1;
    localparam int GAP_MAX      = 16;

    localparam logic [CMD_W-1:0]          CMD_UNUSED = 2'd3;
    localparam logic signed [SCORE_W-1:0] SCORE_MIN  = 32'sh8000_0000;
    localparam logic signed [SCORE_W-1:0] SCORE_MAX  = 32'sh7fff_ffff;

    typedef struct packed {
        t_in  item;
        logic fixed;
        t_out want;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    logic o_done;
    t_in  i_in;
    t_out o_out;

    logic signed [SCORE_W-1:0] score_model [DEPTH];
    t_out result_q[$];
    t_row directed_rows[$];
    int   errors      = 0;
    int   idle_cycles = 0;
    int   sent        = 0;
    bit   burst       = 1'b0;

    top_n_score_insert #(
        .TABLE_DEPTH(DEPTH)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .i_in   (i_in),
        .busy   (busy),
        .o_done (o_done),
        .o_out  (o_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic t_out predict_score(input t_in item);
        logic signed [SCORE_W-1:0] val;
        logic signed [SCORE_W-1:0] tmp;
        t_out res;
        int   best;
        int   cnt;
        val = item.score;
        res = '0;
        case (item.command)
            CMD_INSERT: begin
                if (val > score_model[DEPTH-1]) begin
                    score_model[DEPTH-1] = val;
                    for (int i = 0; i < DEPTH - 1; i++) begin
                        best = i;
                        for (int j = i + 1; j < DEPTH; j++) begin
                            if (score_model[j] > score_model[best]) begin
                                best = j;
                            end
                        end
                        tmp = score_model[i];
                        score_model[i] = score_model[best];
                        score_model[best] = tmp;
                    end
                    cnt = 0;
                    for (int i = 0; i < DEPTH; i++) begin
                        if (score_model[i] > val) begin
                            cnt++;
                        end
                    end
                    res.accepted = 1'b1;
                    res.rank = (cnt > RANK_MAX) ? RANK_MAX[RANK_W-1:0] : cnt[RANK_W-1:0];
                end
            end
            CMD_READ: begin
                if (item.slot < DEPTH) begin
                    res.slot_value = score_model[item.slot];
                end
            end
            CMD_LOAD: begin
                if (item.slot < DEPTH) begin
                    score_model[item.slot] = val;
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    function automatic void add_row(input logic [CMD_W-1:0] cmd,
                                    input logic signed [SCORE_W-1:0] score,
                                    input logic [SLOT_W-1:0] slot,
                                    input logic fixed,
                                    input logic acc,
                                    input logic [RANK_W-1:0] rank,
                                    input logic signed [SCORE_W-1:0] sval);
        t_row r;
        r.item.command   = cmd;
        r.item.score     = score;
        r.item.slot      = slot;
        r.fixed          = fixed;
        r.want.accepted  = acc;
        r.want.rank      = rank;
        r.want.slot_value = sval;
        directed_rows.push_back(r);
    endfunction

    function automatic logic signed [SCORE_W-1:0] clamp_score(input longint v);
        if (v < SCORE_MIN) begin
            return SCORE_MIN;
        end
        if (v > SCORE_MAX) begin
            return SCORE_MAX;
        end
        return v[SCORE_W-1:0];
    endfunction

    function automatic logic signed [SCORE_W-1:0] rand_score();
        longint v;
        int     off;
        case ($urandom_range(0, 5))
            0: v = $signed($urandom);
            1: begin
                case ($urandom_range(0, 3))
                    0:       v = SCORE_MIN;
                    1:       v = SCORE_MAX;
                    2:       v = 0;
                    default: v = -1;
                endcase
            end
            default: begin
                off = $urandom_range(0, 200);
                v = longint'(score_model[$urandom_range(0, DEPTH - 1)]) + off - 100;
            end
        endcase
        return clamp_score(v);
    endfunction

    function automatic t_in rand_item();
        t_in item;
        int  r;
        r = $urandom_range(0, 9);
        if (r < 5) begin
            item.command = CMD_INSERT;
        end else if (r < 7) begin
            item.command = CMD_READ;
        end else if (r < 9) begin
            item.command = CMD_LOAD;
        end else begin
            item.command = CMD_UNUSED;
        end
        item.score = rand_score();
        item.slot  = $urandom_range(0, DEPTH - 1);
        return item;
    endfunction

    task automatic send_cmd(input t_in item, input logic fixed, input t_out want);
        t_out predicted;
        int   gap;
        gap = burst ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_in  <= item;
        do @(posedge i_clk); while (busy);
        predicted = predict_score(item);
        result_q.push_back(fixed ? want : predicted);
        sent++;
    endtask

    // start is already low when nothing is outstanding
    task automatic wait_quiet();
        if (result_q.size() != 0) begin
            start <= 1'b0;
            while (result_q.size() != 0) @(posedge i_clk);
        end
    endtask

    // host rewrites the whole table in non-increasing order, then sends commands, mostly inserts
    task automatic reload_table();
        t_in    item;
        longint v;
        int     step_max;
        int     d;
        int     n_ins;
        v = ($urandom_range(0, 7) == 0) ? longint'(SCORE_MAX)
                                        : longint'($urandom_range(0, 200000)) - 100000;
        case ($urandom_range(0, 3))
            0:       step_max = 0;
            1:       step_max = 1 << 28;
            default: step_max = 1000;
        endcase
        for (int i = 0; i < DEPTH; i++) begin
            item.command = CMD_LOAD;
            item.slot    = i;
            item.score   = clamp_score(v);
            send_cmd(item, 1'b0, '0);
            d = $urandom_range(0, step_max);
            v = v - d;
        end
        n_ins = $urandom_range(2, 8);
        for (int i = 0; i < n_ins; i++) begin
            item = rand_item();
            if ($urandom_range(0, 3) != 0) begin
                item.command = CMD_INSERT;
            end
            send_cmd(item, 1'b0, '0);
        end
    endtask

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n) begin
            if (o_done) begin
                if (result_q.size() == 0) begin
                    $display("%0t unexpected result: expected none, actual %h", $time, o_out);
                    errors++;
                end else begin
                    want = result_q.pop_front();
                    if (o_out.accepted !== want.accepted) begin
                        $display("%0t accepted: expected %0d, actual %0d",
                                 $time, want.accepted, o_out.accepted);
                        errors++;
                    end
                    if (o_out.rank !== want.rank) begin
                        $display("%0t rank: expected %0d, actual %0d",
                                 $time, want.rank, o_out.rank);
                        errors++;
                    end
                    if (o_out.slot_value !== want.slot_value) begin
                        $display("%0t slot_value: expected %0d, actual %0d",
                                 $time, want.slot_value, o_out.slot_value);
                        errors++;
                    end
                end
            end
            if ((start && !busy) || o_done) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t watchdog: no transfer for %0d cycles", $time, idle_cycles);
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial begin
        int total;
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_in    <= '0;
        for (int i = 0; i < DEPTH; i++) begin
            score_model[i] = SCORE_BASE + SCORE_STEP * (DEPTH - 1 - i);
        end

        add_row(CMD_READ,   SCORE_MAX,      0, 1'b1, 1'b0, 0,
                SCORE_BASE + SCORE_STEP * (DEPTH - 1));
        add_row(CMD_READ,   SCORE_MIN,      7, 1'b1, 1'b0, 0, SCORE_BASE);
        add_row(CMD_INSERT, SCORE_BASE,     0, 1'b1, 1'b0, 0, 0);
        add_row(CMD_INSERT, SCORE_MIN,      7, 1'b1, 1'b0, 0, 0);
        add_row(CMD_INSERT, SCORE_BASE + 1, 0, 1'b0, 1'b0, 0, 0);
        add_row(CMD_INSERT, SCORE_MAX,      7, 1'b1, 1'b1, 0, 0);
        add_row(CMD_INSERT, 1200,           0, 1'b0, 1'b0, 0, 0);
        add_row(CMD_READ,   0,              3, 1'b0, 1'b0, 0, 0);
        add_row(CMD_UNUSED, -1,             7, 1'b1, 1'b0, 0, 0);
        add_row(CMD_UNUSED, 0,              0, 1'b1, 1'b0, 0, 0);
        add_row(CMD_LOAD,   SCORE_MAX,      7, 1'b1, 1'b0, 0, 0);
        add_row(CMD_INSERT, 600,            0, 1'b0, 1'b0, 0, 0);
        add_row(CMD_LOAD,   SCORE_MIN,      0, 1'b1, 1'b0, 0, 0);
        add_row(CMD_READ,   -1,             0, 1'b1, 1'b0, 0, SCORE_MIN);
        add_row(CMD_INSERT, -5,             5, 1'b0, 1'b0, 0, 0);
        add_row(CMD_READ,   0,              7, 1'b0, 1'b0, 0, 0);
        add_row(CMD_LOAD,   SCORE_MIN,      7, 1'b1, 1'b0, 0, 0);
        add_row(CMD_INSERT, SCORE_MIN + 1,  0, 1'b0, 1'b0, 0, 0);
        add_row(CMD_INSERT, SCORE_MAX,      0, 1'b0, 1'b0, 0, 0);
        add_row(CMD_READ,   0,              1, 1'b0, 1'b0, 0, 0);
        add_row(CMD_READ,   0,              6, 1'b0, 1'b0, 0, 0);
        add_row(CMD_LOAD,   32'sh5555_5555, 4, 1'b1, 1'b0, 0, 0);
        add_row(CMD_INSERT, 32'sh2aaa_aaaa, 2, 1'b0, 1'b0, 0, 0);
        add_row(CMD_READ,   0,              2, 1'b0, 1'b0, 0, 0);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k]) begin
            send_cmd(directed_rows[k].item, directed_rows[k].fixed, directed_rows[k].want);
        end
        wait_quiet();

        total = sent + N_RANDOM;
        while (sent < total) begin
            if ($urandom_range(0, 19) == 0) begin
                burst = !burst;
            end
            if ($urandom_range(0, 99) == 0) begin
                wait_quiet();
            end
            if ($urandom_range(0, 11) == 0) begin
                reload_table();
            end else begin
                send_cmd(rand_item(), 1'b0, '0);
            end
        end

        wait_quiet();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && result_q.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
